// File: sv/svpwm_pkg.sv
// svpwm_pkg: shared types and constants for the svpwm sector and compare pipeline
// no dependencies; imported by every module of the block
package svpwm_pkg;

    localparam int W_W = 18;

    // sqrt(3) scaled by 2^32, rounded
    localparam logic [63:0] SQRT3_Q32 = 64'd7439101574;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [15:0] CMP_MAX      = 16'hFFFF;
    localparam logic [15:0] CMP_ZERO     = 16'h0000;

    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;

    typedef logic signed [W_W-1:0] t_w;

    // per-item values that ride alongside the divider
    typedef struct packed {
        logic [2:0]  sector;
        t_w          qa;
        t_w          qb;
        logic [15:0] tp;
        logic        fault;
    } t_side;

    typedef struct packed {
        logic [2:0]  sector;
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
        logic        fault;
    } t_res;

endpackage

// File: sv/svpwm_if.sv
// svpwm_if: valid/ready channel interfaces for input words, result words and config
// no dependencies
interface svpwm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] alpha_voltage;
    logic signed [15:0] beta_voltage;
    logic [15:0]        bus_voltage;

    modport source(output valid, output alpha_voltage, output beta_voltage,
                   output bus_voltage, input ready);
    modport sink(input valid, input alpha_voltage, input beta_voltage,
                 input bus_voltage, output ready);
endinterface

interface svpwm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  sector;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic        fault;

    modport source(output valid, output sector, output compare_a, output compare_b,
                   output compare_c, output fault, input ready);
    modport sink(input valid, input sector, input compare_a, input compare_b,
                 input compare_c, input fault, output ready);
endinterface

interface svpwm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] period_counts;

    modport source(output valid, output period_counts, input ready);
    modport sink(input valid, input period_counts, output ready);
endinterface

// File: sv/svpwm_front.sv
// svpwm_front: input register, ratio numerator, alpha scaling, projections and sector pick
// depends on svpwm_pkg
module svpwm_front #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [15:0]        i_alpha,
    input  logic signed [15:0]        i_beta,
    input  logic [15:0]               i_bus,
    input  logic [15:0]               i_period,
    output logic                      o_valid,
    output logic [FRACTION_BITS+17:0] o_num,
    output logic [15:0]               o_bus,
    output svpwm_pkg::t_side          o_side
);
    import svpwm_pkg::*;

    localparam int NW  = FRACTION_BITS + 18;
    localparam int S3W = FRACTION_BITS + 1;
    localparam int SH  = 32 - FRACTION_BITS;
    localparam int UPW = FRACTION_BITS + 18;
    localparam logic [63:0] S3_FULL = (SQRT3_Q32 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [S3W-1:0] S3U = S3_FULL[S3W-1:0];
    localparam logic signed [S3W:0] S3S = {1'b0, S3U};
    localparam logic [UPW-1:0] UMASK = {{(UPW-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};

    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [15:0] r_alpha1, r_alpha2;
    logic signed [15:0] r_beta1, r_beta2, r_beta3;
    logic [15:0]        r_bus1, r_bus2, r_bus3, r_bus4;
    logic [15:0]        r_tp1, r_tp2, r_tp3;
    logic [NW-1:0]      r_num2, r_num3, r_num4;
    t_w                 r_ua3;
    t_side              r_side4;

    logic [NW-1:0]        n_num;
    logic signed [UPW-1:0] n_uprod;
    logic signed [UPW-1:0] n_uadj;
    logic signed [UPW-1:0] n_ush;
    t_w                   n_ua;
    t_w                   n_wx, n_wy, n_wz;
    logic [W_W:0]         n_dy, n_dz, n_dy_adj, n_dz_adj;
    logic [2:0]           n_sector;
    t_w                   n_qa, n_qb;

    // ratio numerator sqrt3 * 2 * period
    assign n_num = NW'(S3U) * NW'({r_tp1, 1'b0});

    // alpha scaled by sqrt3, truncated toward zero
    always_comb begin
        n_uprod = UPW'(r_alpha2) * UPW'(S3S);
        n_uadj  = n_uprod + (n_uprod[UPW-1] ? UMASK : '0);
        n_ush   = n_uadj >>> FRACTION_BITS;
        n_ua    = n_ush[W_W-1:0];
    end

    // projections and sector
    always_comb begin
        n_wx     = {{(W_W-16){r_beta3[15]}}, r_beta3};
        n_dy     = {r_ua3[W_W-1], r_ua3} - {n_wx[W_W-1], n_wx};
        n_dz     = '0 - {n_wx[W_W-1], n_wx} - {r_ua3[W_W-1], r_ua3};
        n_dy_adj = n_dy + {{W_W{1'b0}}, n_dy[W_W]};
        n_dz_adj = n_dz + {{W_W{1'b0}}, n_dz[W_W]};
        n_wy     = n_dy_adj[W_W:1];
        n_wz     = n_dz_adj[W_W:1];

        n_sector = SEC_1;
        n_qa     = n_wy;
        n_qb     = n_wx;
        if (n_wy[W_W-1]) begin
            if (n_wz[W_W-1]) begin
                n_sector = SEC_2;
                n_qa     = -n_wy;
                n_qb     = -n_wz;
            end else if (!n_wx[W_W-1]) begin
                n_sector = SEC_3;
                n_qa     = n_wx;
                n_qb     = n_wz;
            end else begin
                n_sector = SEC_4;
                n_qa     = -n_wx;
                n_qb     = -n_wy;
            end
        end else if (n_wz[W_W-1]) begin
            if (n_wx[W_W-1]) begin
                n_sector = SEC_6;
                n_qa     = -n_wz;
                n_qb     = -n_wx;
            end
        end else if (n_wx[W_W-1]) begin
            n_sector = SEC_5;
            n_qa     = n_wz;
            n_qb     = n_wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha1 <= i_alpha;
            r_beta1  <= i_beta;
            r_bus1   <= i_bus;
            r_tp1    <= i_period;

            r_alpha2 <= r_alpha1;
            r_beta2  <= r_beta1;
            r_bus2   <= r_bus1;
            r_tp2    <= r_tp1;
            r_num2   <= n_num;

            r_beta3  <= r_beta2;
            r_bus3   <= r_bus2;
            r_tp3    <= r_tp2;
            r_num3   <= r_num2;
            r_ua3    <= n_ua;

            r_bus4         <= r_bus3;
            r_num4         <= r_num3;
            r_side4.sector <= n_sector;
            r_side4.qa     <= n_qa;
            r_side4.qb     <= n_qb;
            r_side4.tp     <= r_tp3;
            r_side4.fault  <= (r_bus3 == 16'd0);
        end
    end

    assign o_valid = r_v4;
    assign o_num   = r_num4;
    assign o_bus   = r_bus4;
    assign o_side  = r_side4;

endmodule

// File: sv/svpwm_div.sv
// svpwm_div: pipelined restoring divider, one quotient bit per stage, side data carried along
// depends on svpwm_pkg
module svpwm_div #(
    parameter int NUM_W = 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [15:0]       i_den,
    input  svpwm_pkg::t_side  i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output svpwm_pkg::t_side  o_side
);
    import svpwm_pkg::*;

    logic [NUM_W-1:0] r_v;
    logic [NUM_W-1:0] r_nq   [NUM_W];
    logic [15:0]      r_rem  [NUM_W];
    logic [15:0]      r_den  [NUM_W];
    t_side            r_side [NUM_W];

    logic [NUM_W-1:0] s_nq   [NUM_W];
    logic [15:0]      s_rem  [NUM_W];
    logic [15:0]      s_den  [NUM_W];
    t_side            s_side [NUM_W];
    logic [16:0]      n_t    [NUM_W];
    logic [16:0]      n_diff [NUM_W];
    logic             n_ge   [NUM_W];
    logic [15:0]      n_rem  [NUM_W];
    logic [NUM_W-1:0] n_nq   [NUM_W];

    always_comb begin
        s_nq[0]   = i_num;
        s_rem[0]  = '0;
        s_den[0]  = i_den;
        s_side[0] = i_side;
        for (int k = 1; k < NUM_W; k++) begin
            s_nq[k]   = r_nq[k-1];
            s_rem[k]  = r_rem[k-1];
            s_den[k]  = r_den[k-1];
            s_side[k] = r_side[k-1];
        end
        for (int k = 0; k < NUM_W; k++) begin
            n_t[k]    = {s_rem[k], s_nq[k][NUM_W-1]};
            n_diff[k] = n_t[k] - {1'b0, s_den[k]};
            n_ge[k]   = (n_t[k] >= {1'b0, s_den[k]});
            n_rem[k]  = n_ge[k] ? n_diff[k][15:0] : n_t[k][15:0];
            n_nq[k]   = {s_nq[k][NUM_W-2:0], n_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NUM_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_nq[k]   <= n_nq[k];
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= s_den[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quot  = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// File: sv/svpwm_back.sv
// svpwm_back: active times, zero time, centre-aligned compares, clamp and fault override
// depends on svpwm_pkg
module svpwm_back #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [FRACTION_BITS+17:0] i_m,
    input  svpwm_pkg::t_side          i_side,
    output logic                      o_valid,
    output svpwm_pkg::t_res           o_res
);
    import svpwm_pkg::*;

    localparam int NW = FRACTION_BITS + 18;
    localparam int PW = NW + W_W + 1;
    localparam int TW = NW + 20 - FRACTION_BITS;
    localparam logic [PW-1:0] PMASK = {{(PW-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};

    function automatic logic [TW-1:0] f_scale(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] s;
        a = p + (p[PW-1] ? PMASK : '0);
        s = a >>> FRACTION_BITS;
        return s[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] f_half(input logic [TW-1:0] x);
        logic [TW-1:0] a;
        a = x + {{(TW-1){1'b0}}, x[TW-1]};
        return {a[TW-1], a[TW-1:1]};
    endfunction

    function automatic logic [15:0] f_clamp(input logic [TW-1:0] x);
        logic [15:0] c;
        if (x[TW-1]) begin
            c = CMP_ZERO;
        end else if (|x[TW-2:16]) begin
            c = CMP_MAX;
        end else begin
            c = x[15:0];
        end
        return c;
    endfunction

    logic          r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [NW-1:0] r_m1;
    t_w            r_qb1;
    logic [2:0]    r_sec1, r_sec2, r_sec3, r_sec4;
    logic [15:0]   r_tp1, r_tp2, r_tp3;
    logic          r_flt1, r_flt2, r_flt3, r_flt4;
    logic [TW-1:0] r_ta1, r_ta2, r_tb2;
    logic [TW-1:0] r_t03, r_tah3;
    logic [TW-1:0] r_lo4, r_mid4, r_hi4;
    t_res          r_res5;

    logic signed [PW-1:0] n_pa, n_pb;
    logic [TW-1:0]        n_sum, n_t0, n_lo;
    logic [15:0]          n_lo_c, n_mid_c, n_hi_c;
    t_res                 n_res;

    always_comb begin
        n_pa = PW'($signed({1'b0, i_m})) * PW'($signed(i_side.qa));
        n_pb = PW'($signed({1'b0, r_m1})) * PW'($signed(r_qb1));
    end

    always_comb begin
        n_sum = {{(TW-17){1'b0}}, r_tp2, 1'b0} - r_ta2 - r_tb2;
        n_t0  = f_half(n_sum);
        n_lo  = f_half(r_t03);
    end

    always_comb begin
        n_lo_c  = f_clamp(r_lo4);
        n_mid_c = f_clamp(r_mid4);
        n_hi_c  = f_clamp(r_hi4);
        n_res.sector = r_sec4;
        n_res.fault  = 1'b0;
        unique case (r_sec4)
            SEC_1: begin
                n_res.compare_a = n_lo_c;
                n_res.compare_b = n_mid_c;
                n_res.compare_c = n_hi_c;
            end
            SEC_2: begin
                n_res.compare_a = n_mid_c;
                n_res.compare_b = n_lo_c;
                n_res.compare_c = n_hi_c;
            end
            SEC_3: begin
                n_res.compare_a = n_hi_c;
                n_res.compare_b = n_lo_c;
                n_res.compare_c = n_mid_c;
            end
            SEC_4: begin
                n_res.compare_a = n_hi_c;
                n_res.compare_b = n_mid_c;
                n_res.compare_c = n_lo_c;
            end
            SEC_5: begin
                n_res.compare_a = n_mid_c;
                n_res.compare_b = n_hi_c;
                n_res.compare_c = n_lo_c;
            end
            default: begin
                n_res.compare_a = n_lo_c;
                n_res.compare_b = n_hi_c;
                n_res.compare_c = n_mid_c;
            end
        endcase
        // zero bus voltage
        if (r_flt4) begin
            n_res.sector    = SEC_1;
            n_res.compare_a = CMP_ZERO;
            n_res.compare_b = CMP_ZERO;
            n_res.compare_c = CMP_ZERO;
            n_res.fault     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= i_m;
            r_qb1  <= i_side.qb;
            r_sec1 <= i_side.sector;
            r_tp1  <= i_side.tp;
            r_flt1 <= i_side.fault;
            r_ta1  <= f_scale(n_pa);

            r_sec2 <= r_sec1;
            r_tp2  <= r_tp1;
            r_flt2 <= r_flt1;
            r_ta2  <= r_ta1;
            r_tb2  <= f_scale(n_pb);

            r_sec3 <= r_sec2;
            r_tp3  <= r_tp2;
            r_flt3 <= r_flt2;
            r_t03  <= n_t0;
            r_tah3 <= f_half(r_ta2);

            r_sec4 <= r_sec3;
            r_flt4 <= r_flt3;
            r_lo4  <= n_lo;
            r_mid4 <= n_lo + r_tah3;
            r_hi4  <= {{(TW-16){1'b0}}, r_tp3} - n_lo;

            r_res5 <= n_res;
        end
    end

    assign o_valid = r_v5;
    assign o_res   = r_res5;

endmodule

// File: sv/svpwm_obuf.sv
// svpwm_obuf: two-word output buffer that decouples the pipeline from the result channel
// depends on svpwm_pkg
module svpwm_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  svpwm_pkg::t_res i_word,
    input  logic            i_pop,
    output logic            o_en,
    output logic            o_valid,
    output svpwm_pkg::t_res o_word
);
    import svpwm_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    t_res       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_pop;

    assign n_pop   = i_pop && (r_cnt != 2'd0);
    assign o_en    = (r_cnt != DEPTH);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (n_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, n_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_word;
        end
    end

endmodule

// File: sv/svpwm_sector_compare.sv
// svpwm_sector_compare: space vector pwm sector and compare value pipeline, top level
// depends on svpwm_pkg, svpwm_if, svpwm_front, svpwm_div, svpwm_back, svpwm_obuf
//
//   port    dir  word
//   i_cfg   in   period_counts (16 bit pwm period)
//   i_in    in   alpha_voltage, beta_voltage (q1.15), bus_voltage
//   o_out   out  sector, compare_a, compare_b, compare_c, fault
//
// one word accepted per cycle while the output buffer has room;
// the divider gives one quotient bit per stage over FRACTION_BITS + 18 stages
// all stages advance together while the two-word output buffer has room
// i_in.ready drops only when both buffer words wait on o_out.ready
// synchronous active-low reset empties the pipeline and sets the period to 1000
module svpwm_sector_compare #(
    parameter int FRACTION_BITS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    svpwm_cfg_if.sink         i_cfg,
    svpwm_in_if.sink          i_in,
    svpwm_out_if.source       o_out
);
    import svpwm_pkg::*;

    localparam int NW = FRACTION_BITS + 18;

    logic [15:0]   r_period;
    logic          w_en;
    logic          w_fr_valid;
    logic [NW-1:0] w_fr_num;
    logic [15:0]   w_fr_bus;
    t_side         w_fr_side;
    logic          w_dv_valid;
    logic [NW-1:0] w_dv_quot;
    t_side         w_dv_side;
    logic          w_bk_valid;
    t_res          w_bk_res;
    t_res          w_out_word;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg.valid) begin
            r_period <= i_cfg.period_counts;
        end
    end

    assign i_in.ready = w_en;

    svpwm_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in.valid),
        .i_alpha  (i_in.alpha_voltage),
        .i_beta   (i_in.beta_voltage),
        .i_bus    (i_in.bus_voltage),
        .i_period (r_period),
        .o_valid  (w_fr_valid),
        .o_num    (w_fr_num),
        .o_bus    (w_fr_bus),
        .o_side   (w_fr_side)
    );

    svpwm_div #(.NUM_W(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_num   (w_fr_num),
        .i_den   (w_fr_bus),
        .i_side  (w_fr_side),
        .o_valid (w_dv_valid),
        .o_quot  (w_dv_quot),
        .o_side  (w_dv_side)
    );

    svpwm_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_valid),
        .i_m     (w_dv_quot),
        .i_side  (w_dv_side),
        .o_valid (w_bk_valid),
        .o_res   (w_bk_res)
    );

    svpwm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_bk_valid),
        .i_word  (w_bk_res),
        .i_pop   (o_out.ready),
        .o_en    (w_en),
        .o_valid (o_out.valid),
        .o_word  (w_out_word)
    );

    assign o_out.sector    = w_out_word.sector;
    assign o_out.compare_a = w_out_word.compare_a;
    assign o_out.compare_b = w_out_word.compare_b;
    assign o_out.compare_c = w_out_word.compare_c;
    assign o_out.fault     = w_out_word.fault;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.fault |-> o_out.sector == SEC_1 &&
            o_out.compare_a == CMP_ZERO && o_out.compare_b == CMP_ZERO &&
            o_out.compare_c == CMP_ZERO)
        else $error("fault word with nonzero compares");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.sector >= SEC_1 && o_out.sector <= SEC_6)
        else $error("sector out of range");

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no word waiting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && i_in.ready)
        else $error("pipeline not empty after reset");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for svpwm_sector_compare, directed table then random words
// depends on svpwm_pkg, svpwm_if and the svpwm_sector_compare rtl
module tb;
    import svpwm_pkg::*;

    localparam int FRAC = 15;
    localparam int N_DIR = 24;
    localparam int N_PHASE = 5;
    localparam int WORDS_PER_PHASE = 160;

    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [15:0]        bus;
        logic               typed;
        t_res               res;
    } t_dir_row;

    localparam t_res PRED = '{SEC_1, CMP_ZERO, CMP_ZERO, CMP_ZERO, 1'b0};
    localparam t_res FLT  = '{SEC_1, CMP_ZERO, CMP_ZERO, CMP_ZERO, 1'b1};

    // typed rows assume the reset period of 1000
    t_dir_row dir_rows [0:N_DIR-1] = '{
        '{16'sd0, 16'sd0, 16'd32768, 1'b1, '{SEC_1, 16'd500, 16'd500, 16'd500, 1'b0}},
        '{16'sd0, 16'sd0, 16'd0, 1'b1, FLT},
        '{16'sd16000, 16'sd8000, 16'd0, 1'b1, FLT},
        '{-16'sd32768, -16'sd32768, 16'd0, 1'b1, FLT},
        '{16'sd16000, 16'sd8000, 16'd32768, 1'b0, PRED},
        '{16'sd0, 16'sd16000, 16'd32768, 1'b0, PRED},
        '{-16'sd16000, 16'sd8000, 16'd32768, 1'b0, PRED},
        '{-16'sd16000, -16'sd8000, 16'd32768, 1'b0, PRED},
        '{16'sd0, -16'sd16000, 16'd32768, 1'b0, PRED},
        '{16'sd16000, -16'sd8000, 16'd32768, 1'b0, PRED},
        '{16'sd1, 16'sd0, 16'd32768, 1'b0, PRED},
        '{-16'sd1, 16'sd0, 16'd32768, 1'b0, PRED},
        '{16'sd0, 16'sd1, 16'd32768, 1'b0, PRED},
        '{16'sd32767, 16'sd32767, 16'd65535, 1'b0, PRED},
        '{-16'sd32768, -16'sd32768, 16'd65535, 1'b0, PRED},
        '{16'sd32767, -16'sd32768, 16'd1, 1'b0, PRED},
        '{-16'sd32768, 16'sd32767, 16'd1, 1'b0, PRED},
        '{16'sd32767, 16'sd0, 16'd1, 1'b0, PRED},
        '{16'sd0, -16'sd32768, 16'd1, 1'b0, PRED},
        '{16'sd0, 16'sd0, 16'd1, 1'b0, PRED},
        '{16'sd0, 16'sd0, 16'd65535, 1'b0, PRED},
        '{-16'sd32768, 16'sd0, 16'd65535, 1'b0, PRED},
        '{16'sd0, 16'sd32767, 16'd32768, 1'b0, PRED},
        '{16'sd12345, -16'sd23456, 16'd40000, 1'b0, PRED}
    };

    logic i_clk;
    logic i_rst_n;

    svpwm_cfg_if cfg_if ();
    svpwm_in_if  in_if ();
    svpwm_out_if out_if ();

    svpwm_sector_compare #(.FRACTION_BITS(FRAC)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_res        compare_q[$];
    logic [15:0] period_shadow;
    bit          steady;
    int          n_err;
    int          n_words;
    int          n_results;
    int          n_faults;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_400_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [15:0] clamp_cmp(longint v);
        if (v < 0) return CMP_ZERO;
        if (v > 65535) return CMP_MAX;
        return v[15:0];
    endfunction

    function automatic t_res predict_compare(logic signed [15:0] a, logic signed [15:0] b,
                                             logic [15:0] udc, logic [15:0] tp);
        longint one, s3, m, tpl, ua, wx, wy, wz, ta, tb, t0, lo, mid, hi, ca, cb, cc;
        t_res r;
        r = PRED;
        if (udc == 16'd0) begin
            r.fault = 1'b1;
            return r;
        end
        one = longint'(1) << FRAC;
        s3  = (longint'(SQRT3_Q32) + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC);
        tpl = longint'(tp);
        m   = s3 * 2 * tpl / longint'(udc);
        ua  = longint'(a) * s3 / one;
        wx  = longint'(b);
        wy  = (ua - wx) / 2;
        wz  = (-wx - ua) / 2;
        if (wy < 0) begin
            if (wz < 0) begin
                r.sector = SEC_2; ta = -(m * wy) / one; tb = -(m * wz) / one;
            end else if (wx >= 0) begin
                r.sector = SEC_3; ta = (m * wx) / one; tb = (m * wz) / one;
            end else begin
                r.sector = SEC_4; ta = -(m * wx) / one; tb = -(m * wy) / one;
            end
        end else if (wz < 0) begin
            if (wx >= 0) begin
                r.sector = SEC_1; ta = (m * wy) / one; tb = (m * wx) / one;
            end else begin
                r.sector = SEC_6; ta = -(m * wz) / one; tb = -(m * wx) / one;
            end
        end else if (wx < 0) begin
            r.sector = SEC_5; ta = (m * wz) / one; tb = (m * wy) / one;
        end else begin
            r.sector = SEC_1; ta = (m * wy) / one; tb = (m * wx) / one;
        end
        t0  = (2 * tpl - ta - tb) / 2;
        lo  = t0 / 2;
        mid = t0 / 2 + ta / 2;
        hi  = tpl - t0 / 2;
        case (r.sector)
            SEC_1: begin ca = lo;  cb = mid; cc = hi;  end
            SEC_2: begin ca = mid; cb = lo;  cc = hi;  end
            SEC_3: begin ca = hi;  cb = lo;  cc = mid; end
            SEC_4: begin ca = hi;  cb = mid; cc = lo;  end
            SEC_5: begin ca = mid; cb = hi;  cc = lo;  end
            default: begin ca = lo; cb = hi; cc = mid; end
        endcase
        r.compare_a = clamp_cmp(ca);
        r.compare_b = clamp_cmp(cb);
        r.compare_c = clamp_cmp(cc);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            n_err++;
            $display("%0t ns: %s expected %0d got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_results++;
            if (compare_q.size() == 0) begin
                n_err++;
                $display("%0t ns: result word with none expected, sector %0d", $time,
                         out_if.sector);
            end else begin
                want = compare_q.pop_front();
                check_field("sector", want.sector, out_if.sector);
                check_field("compare_a", want.compare_a, out_if.compare_a);
                check_field("compare_b", want.compare_b, out_if.compare_b);
                check_field("compare_c", want.compare_c, out_if.compare_c);
                check_field("fault", want.fault, out_if.fault);
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    task automatic send_word(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic [15:0] u, input logic typed, input t_res typed_res);
        bit go;
        go = 1'b0;
        while (!go) begin
            @(negedge i_clk);
            if (steady || $urandom_range(0, 99) >= 32) go = 1'b1;
            else in_if.valid <= 1'b0;
        end
        in_if.valid         <= 1'b1;
        in_if.alpha_voltage <= a;
        in_if.beta_voltage  <= b;
        in_if.bus_voltage   <= u;
        do @(posedge i_clk); while (!in_if.ready);
        if (typed) compare_q.push_back(typed_res);
        else compare_q.push_back(predict_compare(a, b, u, period_shadow));
        n_words++;
        if (u == 16'd0) n_faults++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (compare_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [15:0] v);
        @(negedge i_clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.period_counts <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        period_shadow = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic gen_word(output logic signed [15:0] a, output logic signed [15:0] b,
                            output logic [15:0] u);
        int unsigned kind;
        int unsigned pick;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        a = 16'($urandom);
        b = 16'($urandom);
        u = 16'($urandom);
        if (kind < 10) begin
            u = 16'd0;
        end else if (kind < 20) begin
            a = 16'($urandom_range(0, 6) - 3);
            b = 16'($urandom_range(0, 6) - 3);
        end else if (kind < 30) begin
            if (pick < 5) b = 16'sd0;
            else a = 16'sd0;
        end else if (pick < 4) begin
            u = 16'($urandom);
        end else if (pick < 8) begin
            u = 16'($urandom_range(16384, 65535));
        end else begin
            u = 16'($urandom_range(1, 255));
        end
    endtask

    initial begin
        logic signed [15:0] a, b;
        logic [15:0]        u;
        logic [15:0]        periods [0:N_PHASE-1];
        in_if.valid          = 1'b0;
        in_if.alpha_voltage  = '0;
        in_if.beta_voltage   = '0;
        in_if.bus_voltage    = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.period_counts = '0;
        i_rst_n              = 1'b0;
        steady               = 1'b0;
        n_err                = 0;
        n_words              = 0;
        n_results            = 0;
        n_faults             = 0;
        period_shadow        = PERIOD_RESET;
        periods[0] = 16'd1;
        periods[1] = 16'd65535;
        periods[2] = 16'($urandom_range(2, 65534));
        periods[3] = 16'($urandom_range(2, 200));
        periods[4] = PERIOD_RESET;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_word(dir_rows[i].alpha, dir_rows[i].beta, dir_rows[i].bus,
                      dir_rows[i].typed, dir_rows[i].res);
        drain();

        for (int p = 0; p < N_PHASE; p++) begin
            write_period(periods[p]);
            steady = (p == 2);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (i == WORDS_PER_PHASE / 2) drain();
                gen_word(a, b, u);
                send_word(a, b, u, 1'b0, PRED);
            end
            drain();
        end
        steady = 1'b0;

        repeat (60) @(posedge i_clk);
        if (compare_q.size() != 0) begin
            n_err++;
            $display("%0t ns: %0d result words never arrived", $time, compare_q.size());
        end
        $display("covered %0d words (%0d with zero bus) and %0d results", n_words, n_faults,
                 n_results);
        $display("periods 1, 65535, %0d, %0d and 1000 after the reset default", periods[2],
                 periods[3]);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/svpwm_pkg.sv
sv/svpwm_if.sv
sv/svpwm_front.sv
sv/svpwm_div.sv
sv/svpwm_back.sv
sv/svpwm_obuf.sv
sv/svpwm_sector_compare.sv
sim/tb.sv
